// File: rtl/dwg_pkg.sv
// Shared types and constants for the DAC waveform sample generator.
// Used by every module under rtl/; depends on nothing.
package dwg_pkg;

    localparam int IDX_W = 13;
    localparam int LEN_W = 14;
    localparam int Q_W   = 32;
    localparam int DEF_TABLE_LEN_MAX = 8192;

    // Wave kinds
    localparam logic [1:0] KIND_SINE     = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_KIND  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_KIND   = 3'd0;
    localparam logic [2:0] REG_AMP    = 3'd1;
    localparam logic [2:0] REG_OFFSET = 3'd2;
    localparam logic [2:0] REG_PHASE  = 3'd3;
    localparam logic [2:0] REG_ASPECT = 3'd4;
    localparam logic [2:0] REG_LENGTH = 3'd5;

    // Sine polynomial coefficients, Q30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598668;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172272;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [1:0]       status;
        logic             is_sine;
        logic             is_rise;
    } t_tag;

    typedef struct packed {
        t_tag             tag;
        logic [LEN_W-1:0] num;
        logic [LEN_W-1:0] den;
    } t_job;

endpackage

// File: rtl/dac_waveform_sample_generator.sv
// Top level of the DAC waveform sample generator: configuration registers,
// front end, job queue, divider pipeline and back end. Depends on dwg_pkg.
//
// Usage: each index written on the slave stream (tdata[12:0]) yields one result
// on the master stream: tdata holds the 12-bit DAC code and the echoed index,
// tuser holds the status (ok, index beyond length, unsupported kind).
// Configuration is written through i_cfg_we/i_cfg_addr/i_cfg_wdata while the
// block is idle; a write takes effect at the next clock edge.
// Throughput: one index per clock while the receiver does not stall. The divider
// pipeline forms one quotient bit per stage and makes up most of the pipeline: the
// front register loads at the accepting edge, then a sample passes the queue
// write, 33 divider stages, 9 shaping and scaling stages and the output register.
// Reset clears all valid flags and loads the default register values; the
// block accepts input as soon as reset is released.
// When the receiver stalls, the back end and divider hold; the two-entry queue
// and the front register then fill, after which tready drops.
module dac_waveform_sample_generator #(
    parameter int TABLE_LEN_MAX = dwg_pkg::DEF_TABLE_LEN_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [12:0] sample_index
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [11:0] sample_value, [24:12] index_echo
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [29:0] i_cfg_wdata
);
    import dwg_pkg::*;

    logic [1:0]         r_kind;
    logic signed [15:0] r_amp;
    logic signed [15:0] r_offset;
    logic [15:0]        r_phase;
    logic [29:0]        r_aspect;
    logic [LEN_W-1:0]   r_length;

    logic               w_front_vld;
    t_job               w_front_job;
    logic               w_full;
    logic               w_empty;
    t_job               w_fifo_job;
    logic               w_en;
    logic               w_div_vld;
    t_tag               w_div_tag;
    logic [Q_W-1:0]     w_quot;
    logic [11:0]        w_value;
    logic [IDX_W-1:0]   w_idx;
    logic [1:0]         w_status;
    logic [LEN_W-1:0]   w_len_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_SINE;
            r_amp    <= 16'sd16384;
            r_offset <= '0;
            r_phase  <= '0;
            r_aspect <= 30'd32768;
            r_length <= LEN_W'(8192);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_KIND:   r_kind   <= i_cfg_wdata[1:0];
                REG_AMP:    r_amp    <= i_cfg_wdata[15:0];
                REG_OFFSET: r_offset <= i_cfg_wdata[15:0];
                REG_PHASE:  r_phase  <= i_cfg_wdata[15:0];
                REG_ASPECT: r_aspect <= i_cfg_wdata;
                REG_LENGTH: r_length <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    dwg_front #(.TABLE_LEN_MAX(TABLE_LEN_MAX)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_idx    (i_s_axis_tdata[IDX_W-1:0]),
        .i_kind   (r_kind),
        .i_aspect (r_aspect),
        .i_length (r_length),
        .o_valid  (w_front_vld),
        .i_full   (w_full),
        .o_job    (w_front_job)
    );

    dwg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_vld),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_en),
        .o_empty (w_empty),
        .o_job   (w_fifo_job)
    );

    dwg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!w_empty),
        .i_job   (w_fifo_job),
        .o_valid (w_div_vld),
        .o_tag   (w_div_tag),
        .o_quot  (w_quot)
    );

    dwg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_div_vld),
        .i_tag    (w_div_tag),
        .i_quot   (w_quot),
        .i_phase  (r_phase),
        .i_amp    (r_amp),
        .i_offset (r_offset),
        .o_en     (w_en),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_value  (w_value),
        .o_idx    (w_idx),
        .o_status (w_status)
    );

    assign o_m_axis_tdata = {7'b0, w_idx, w_value};
    assign o_m_axis_tuser = w_status;

    assign w_len_cap = (17'(r_length) > 17'(TABLE_LEN_MAX)) ? LEN_W'(TABLE_LEN_MAX) : r_length;

    // A rejected sample never carries a nonzero code.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_OK |-> o_m_axis_tdata[11:0] == 12'd0)
        else $error("rejected sample has nonzero code");

    // An accepted status means the index lay inside the configured period.
    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_OK |-> LEN_W'(o_m_axis_tdata[24:12]) < w_len_cap)
        else $error("ok status for index beyond length");

    // With an unsupported kind configured, every result reports it.
    a_kind_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_kind != KIND_SINE && r_kind != KIND_TRIANGLE
        |-> o_m_axis_tuser == ST_KIND)
        else $error("unsupported kind not flagged");

endmodule

// File: rtl/dwg_front.sv
// Front end: accepts sample indexes, classifies them and sets up the division.
// Depends on dwg_pkg.
module dwg_front #(
    parameter int TABLE_LEN_MAX = dwg_pkg::DEF_TABLE_LEN_MAX
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [dwg_pkg::IDX_W-1:0] i_idx,
    input  logic [1:0]                i_kind,
    input  logic [29:0]               i_aspect,
    input  logic [dwg_pkg::LEN_W-1:0] i_length,
    output logic                      o_valid,
    input  logic                      i_full,
    output dwg_pkg::t_job             o_job
);
    import dwg_pkg::*;

    logic             r_vld;
    t_job             r_job;
    t_job             n_job;
    logic             w_push;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_rise;
    logic [LEN_W-1:0] w_rise_raw;
    logic [29:0]      w_frac;
    logic [LEN_W-1:0] w_idx;

    assign w_push  = r_vld && !i_full;
    assign o_ready = !r_vld || w_push;
    assign o_valid = r_vld;
    assign o_job   = r_job;

    always_comb begin
        w_len = (17'(i_length) > 17'(TABLE_LEN_MAX)) ? LEN_W'(TABLE_LEN_MAX) : i_length;
        w_frac = 30'(w_len) * 30'(i_aspect[15:0]);
        w_rise_raw = (i_aspect < 30'd65536) ? w_frac[29:16] : i_aspect[29:16];
        w_rise = (w_rise_raw > w_len) ? w_len : w_rise_raw;
        w_idx = LEN_W'(i_idx);
        n_job.tag.idx     = i_idx;
        n_job.tag.is_sine = (i_kind == KIND_SINE);
        n_job.tag.is_rise = (w_idx < w_rise);
        if (i_kind != KIND_SINE && i_kind != KIND_TRIANGLE) begin
            n_job.tag.status = ST_KIND;
        end else if (w_idx >= w_len) begin
            n_job.tag.status = ST_RANGE;
        end else begin
            n_job.tag.status = ST_OK;
        end
        if (n_job.tag.status != ST_OK) begin
            n_job.num = '0;
            n_job.den = LEN_W'(1);
        end else if (n_job.tag.is_sine) begin
            n_job.num = w_idx;
            n_job.den = w_len;
        end else if (n_job.tag.is_rise) begin
            n_job.num = w_idx;
            n_job.den = w_rise;
        end else begin
            n_job.num = w_idx - w_rise;
            n_job.den = w_len - w_rise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// File: rtl/dwg_fifo.sv
// Two-entry queue of classified jobs between the front and back ends.
// Depends on dwg_pkg.
module dwg_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dwg_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output dwg_pkg::t_job o_job
);
    import dwg_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_do_push;
    logic       w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_job     = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr <= !r_wr;
            end
            if (w_do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(w_do_push) - 2'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: rtl/dwg_div.sv
// Pipelined restoring divider: floor(num * 2^32 / den) for num < den, one bit a stage.
// Depends on dwg_pkg.
module dwg_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  dwg_pkg::t_job           i_job,
    output logic                    o_valid,
    output dwg_pkg::t_tag           o_tag,
    output logic [dwg_pkg::Q_W-1:0] o_quot
);
    import dwg_pkg::*;

    logic             r_vld [0:Q_W];
    t_tag             r_tag [0:Q_W];
    logic [LEN_W-1:0] r_rem [0:Q_W];
    logic [LEN_W-1:0] r_den [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_job.tag;
            r_rem[0] <= i_job.num;
            r_den[0] <= i_job.den;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [LEN_W:0] w_rem2;
        logic           w_ge;
        assign w_rem2 = {r_rem[k], 1'b0};
        assign w_ge   = (w_rem2 >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k+1] <= r_tag[k];
                r_den[k+1] <= r_den[k];
                r_rem[k+1] <= w_ge ? LEN_W'(w_rem2 - {1'b0, r_den[k]}) : w_rem2[LEN_W-1:0];
                r_q[k+1]   <= {r_q[k][Q_W-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_tag   = r_tag[Q_W];
    assign o_quot  = r_q[Q_W];

endmodule

// File: rtl/dwg_back.sv
// Back end: shapes the quotient into a sine or triangle value, scales it to a
// DAC code and holds the result in the output register. Depends on dwg_pkg.
module dwg_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  dwg_pkg::t_tag           i_tag,
    input  logic [dwg_pkg::Q_W-1:0] i_quot,
    input  logic [15:0]             i_phase,
    input  logic signed [15:0]      i_amp,
    input  logic signed [15:0]      i_offset,
    output logic                    o_en,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [11:0]             o_value,
    output logic [dwg_pkg::IDX_W-1:0] o_idx,
    output logic [1:0]              o_status
);
    import dwg_pkg::*;

    localparam int NS = 9;

    // Stage indexes: 0 fold, 1 z^2, 2..5 Horner steps, 6 sine out, 7 amp, 8 norm
    logic               r_vld  [0:NS-1];
    t_tag               r_tag  [0:NS-1];
    logic [30:0]        r_z    [0:NS-1];
    logic               r_neg  [0:NS-1];
    logic signed [31:0] r_tri  [0:NS-1];
    logic [30:0]        r_z2;
    logic [31:0]        r_p;
    logic signed [31:0] r_s;
    logic signed [47:0] r_prod;
    logic signed [48:0] r_norm;
    logic               r_out_vld;
    logic [11:0]        r_out_val;
    t_tag               r_out_tag;

    logic [31:0]        w_ang;
    logic [30:0]        w_zf;
    logic [31:0]        w_t2;
    logic signed [31:0] w_tri;
    logic [63:0]        w_m1;
    logic [63:0]        w_m2;
    logic [63:0]        w_m6;
    logic [31:0]        w_sp;
    logic signed [47:0] w_prod;
    logic signed [48:0] w_norm;
    logic signed [59:0] w_nx;
    logic signed [59:0] w_y;
    logic [11:0]        w_code;

    assign o_en     = !r_out_vld || i_ready;
    assign o_valid  = r_out_vld;
    assign o_value  = r_out_val;
    assign o_idx    = r_out_tag.idx;
    assign o_status = r_out_tag.status;

    always_comb begin
        w_ang = i_quot + {i_phase, 16'b0};
        w_zf  = w_ang[30] ? (31'h4000_0000 - {1'b0, w_ang[29:0]}) : {1'b0, w_ang[29:0]};
        w_t2  = {i_quot[31:2], 2'b0} >> 1;
        w_tri = i_tag.is_rise ? ($signed(w_t2) - 32'sh4000_0000)
                              : (32'sh4000_0000 - $signed(w_t2));
        w_m1  = 64'(r_z[0]) * 64'(r_z[0]);
        w_m2  = 64'(r_z2) * 64'(SIN_C9);
        w_m6  = 64'(r_z[5]) * 64'(r_p);
        w_sp  = (w_m6[61:30] > 32'h4000_0000) ? 32'h4000_0000 : w_m6[61:30];
        w_prod = $signed({{32{i_amp[15]}}, i_amp}) * $signed({{16{r_s[31]}}, r_s});
        w_norm = (49'sd1 <<< 44) + 49'(r_prod) + $signed({{3{i_offset[15]}}, i_offset, 30'b0});
        w_nx   = 60'(r_norm);
        w_y    = (w_nx <<< 11) - w_nx + (60'sd1 <<< 43);
        if (w_y < 0) begin
            w_code = '0;
        end else if (w_y[58:44] > 15'd4095) begin
            w_code = 12'd4095;
        end else begin
            w_code = w_y[55:44];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (o_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_tag[0] <= i_tag;
            r_z[0]   <= w_zf;
            r_neg[0] <= w_ang[31];
            r_tri[0] <= w_tri;
            for (int k = 1; k < NS; k++) begin
                r_tag[k] <= r_tag[k-1];
                r_z[k]   <= r_z[k-1];
                r_neg[k] <= r_neg[k-1];
                r_tri[k] <= r_tri[k-1];
            end
        end
    end

    // Datapath stages; stages 1 to 7 use one multiplier each.
    logic [30:0] r_z2_h [1:5];
    logic [31:0] r_ph   [2:5];
    logic [63:0] w_mh3;
    logic [63:0] w_mh4;
    logic [63:0] w_mh5;

    assign w_mh3 = 64'(r_z2_h[2]) * 64'(r_ph[2]);
    assign w_mh4 = 64'(r_z2_h[3]) * 64'(r_ph[3]);
    assign w_mh5 = 64'(r_z2_h[4]) * 64'(r_ph[4]);
    assign r_z2  = r_z2_h[1];
    assign r_p   = r_ph[5];

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_z2_h[1] <= w_m1[60:30];
            r_z2_h[2] <= r_z2_h[1];
            r_z2_h[3] <= r_z2_h[2];
            r_z2_h[4] <= r_z2_h[3];
            r_z2_h[5] <= r_z2_h[4];
            r_ph[2]   <= SIN_C7 - w_m2[61:30];
            r_ph[3]   <= SIN_C5 - w_mh3[61:30];
            r_ph[4]   <= SIN_C3 - w_mh4[61:30];
            r_ph[5]   <= SIN_C1 - w_mh5[61:30];
            // The final sine product is formed from stage 5 data.
            if (r_tag[5].is_sine) begin
                r_s <= r_neg[5] ? -$signed(w_sp) : $signed(w_sp);
            end else begin
                r_s <= r_tri[5];
            end
            r_prod    <= w_prod;
            r_norm    <= w_norm;
            r_out_tag <= r_tag[NS-1];
            r_out_val <= (r_tag[NS-1].status == ST_OK) ? w_code : 12'd0;
        end
    end

endmodule
